// ----- hdl/ksds_pkg.sv -----
// Shared types and constants for the k smallest distance selector.
// No dependencies; used by ksds_cell and k_smallest_distance_selector.
package ksds_pkg;

  // Fixed field widths of the register and the result rank
  localparam int unsigned NC_W   = 5;
  localparam int unsigned RANK_W = 4;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  // Register index of the neighbour count
  localparam logic REG_NEIGHBOUR_COUNT = 1'b0;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic insert;  // place the new request into the sorted list
    logic shift;   // move every entry one cell toward the output
  } cell_ctl_t;

endpackage

// ----- hdl/ksds_cell.sv -----
// One cell of the sorted insertion chain: holds one kept distance and index.
// Depends on ksds_pkg (cell_ctl_t).
module ksds_cell import ksds_pkg::*; #(
  parameter int unsigned DIST_BITS  = 32,
  parameter int unsigned INDEX_BITS = 16
) (
  input  logic                  clk,
  input  cell_ctl_t             ctl,
  input  logic                  occupied,
  input  logic                  at_fill,
  input  logic                  prev_le,
  input  logic [DIST_BITS-1:0]  new_dist,
  input  logic [INDEX_BITS-1:0] new_index,
  input  logic [DIST_BITS-1:0]  prev_dist,
  input  logic [INDEX_BITS-1:0] prev_index,
  input  logic [DIST_BITS-1:0]  next_dist,
  input  logic [INDEX_BITS-1:0] next_index,
  output logic                  le,
  output logic                  lt,
  output logic [DIST_BITS-1:0]  dist_r,
  output logic [INDEX_BITS-1:0] index_r
);

  logic [DIST_BITS-1:0]  dist_nxt;
  logic [INDEX_BITS-1:0] index_nxt;

  // Compare the new request against the held entry
  assign le = occupied && (new_dist <= dist_r);
  assign lt = occupied && (new_dist < dist_r);

  // Choose: shift out, take from the lower neighbor, take the new entry, or hold
  always_comb begin
    dist_nxt  = dist_r;
    index_nxt = index_r;
    if (ctl.shift) begin
      dist_nxt  = next_dist;
      index_nxt = next_index;
    end else if (ctl.insert) begin
      if (prev_le) begin
        dist_nxt  = prev_dist;
        index_nxt = prev_index;
      end else if (le || at_fill) begin
        dist_nxt  = new_dist;
        index_nxt = new_index;
      end
    end
  end

  always_ff @(posedge clk) begin
    dist_r  <= dist_nxt;
    index_r <= index_nxt;
  end

endmodule

// ----- hdl/k_smallest_distance_selector.sv -----
// Top level of the k smallest distance selector: control, APB register, cell chain.
// Depends on ksds_pkg and ksds_cell.
//
// Usage: present a distance request on in_distance / in_ref_index / in_row_end
// with start high; it is taken at a rising edge where start is high and busy
// is low. Each request is placed into an ascending list of the neighbour_count
// smallest distances (a new distance goes ahead of equal kept ones) in the
// same cycle, so requests without in_row_end are taken one per cycle.
// A request with in_row_end is inserted, then busy rises and the kept entries
// leave one per cycle, rank 0 first, out_valid high for one cycle each and
// out_last_of_row on the final one. The first result appears the cycle after
// the row end request; a row end yields n results for n kept entries
// (1..K_MAX), as the chain shifts one entry a cycle toward the output.
// Results cannot be held off: each is valid for exactly one cycle.
// neighbour_count lies at byte address 0 of the APB port, reset value 1;
// 0 acts as 1, values above K_MAX act as K_MAX. Write it only while idle.
// Reset (rst_n low, synchronous) empties the list and ends any output burst.
module k_smallest_distance_selector import ksds_pkg::*; #(
  parameter int unsigned K_MAX      = 16,
  parameter int unsigned INDEX_BITS = 16,
  parameter int unsigned DIST_BITS  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input request channel
  input  logic                  start,
  output logic                  busy,
  input  logic [DIST_BITS-1:0]  in_distance,
  input  logic [INDEX_BITS-1:0] in_ref_index,
  input  logic                  in_row_end,
  // result channel
  output logic                  out_valid,
  output logic [RANK_W-1:0]     out_rank,
  output logic [INDEX_BITS-1:0] out_nearest_index,
  output logic [DIST_BITS-1:0]  out_nearest_distance,
  output logic                  out_last_of_row,
  // configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [DATA_W-1:0]     pwdata,
  output logic [DATA_W-1:0]     prdata,
  output logic                  pready
);

  localparam int unsigned CNT_W = $clog2(K_MAX + 1);
  localparam int unsigned RK_W  = (K_MAX > 1) ? $clog2(K_MAX) : 1;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic                  state_r, state_nxt;
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [RK_W-1:0]       rank_r, rank_nxt;
  logic [RK_W-1:0]       last_r, last_nxt;
  logic [NC_W-1:0]       nc_r;

  logic [CNT_W-1:0]      k_eff;
  logic [CNT_W-1:0]      fill_eff;
  logic [CNT_W-1:0]      ins_fill;
  logic                  accept;
  logic                  do_insert;
  logic                  tail_lt;
  cell_ctl_t             ctl;

  logic [K_MAX-1:0]      occ, at_fill, le, lt, prev_le, tail;
  logic [DIST_BITS-1:0]  cell_dist  [K_MAX];
  logic [INDEX_BITS-1:0] cell_index [K_MAX];
  logic [DIST_BITS-1:0]  prev_dist  [K_MAX];
  logic [INDEX_BITS-1:0] prev_index [K_MAX];
  logic [DIST_BITS-1:0]  next_dist  [K_MAX];
  logic [INDEX_BITS-1:0] next_index [K_MAX];

  // APB register: always ready, one register at address 0
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NEIGHBOUR_COUNT) ? DATA_W'(nc_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= NC_W'(1);
    end else if (psel && penable && pwrite && pready &&
                 (paddr[2] == REG_NEIGHBOUR_COUNT)) begin
      nc_r <= pwdata[NC_W-1:0];
    end
  end

  // Clamp the count to 1..K_MAX
  always_comb begin
    if (nc_r == '0) begin
      k_eff = CNT_W'(1);
    end else if (32'(nc_r) > K_MAX) begin
      k_eff = CNT_W'(K_MAX);
    end else begin
      k_eff = CNT_W'(nc_r);
    end
  end

  // Cut the list to the current count
  assign fill_eff = (fill_r > k_eff) ? k_eff : fill_r;

  // Per-cell position flags and neighbor wiring
  for (genvar i = 0; i < K_MAX; i++) begin : g_flags
    assign occ[i]     = (CNT_W'(i) < fill_eff);
    assign at_fill[i] = (CNT_W'(i) == fill_eff);
    assign tail[i]    = (CNT_W'(i) == (k_eff - CNT_W'(1)));
    if (i == 0) begin : g_first
      assign prev_le[i]    = 1'b0;
      assign prev_dist[i]  = '0;
      assign prev_index[i] = '0;
    end else begin : g_mid
      assign prev_le[i]    = le[i-1];
      assign prev_dist[i]  = cell_dist[i-1];
      assign prev_index[i] = cell_index[i-1];
    end
    if (i == K_MAX - 1) begin : g_last
      assign next_dist[i]  = '0;
      assign next_index[i] = '0;
    end else begin : g_inner
      assign next_dist[i]  = cell_dist[i+1];
      assign next_index[i] = cell_index[i+1];
    end
  end

  // Strictly below the largest kept entry when the list is full
  assign tail_lt = |(lt & tail);

  assign busy      = (state_r == ST_EMIT);
  assign accept    = start && !busy;
  assign do_insert = accept && ((fill_eff < k_eff) || tail_lt);
  assign ins_fill  = (fill_eff < k_eff) ? (fill_eff + CNT_W'(1)) : fill_eff;

  assign ctl.insert = do_insert;
  assign ctl.shift  = (state_r == ST_EMIT);

  // Cell chain
  for (genvar i = 0; i < K_MAX; i++) begin : g_cell
    ksds_cell #(
      .DIST_BITS  (DIST_BITS),
      .INDEX_BITS (INDEX_BITS)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .occupied   (occ[i]),
      .at_fill    (at_fill[i]),
      .prev_le    (prev_le[i]),
      .new_dist   (in_distance),
      .new_index  (in_ref_index),
      .prev_dist  (prev_dist[i]),
      .prev_index (prev_index[i]),
      .next_dist  (next_dist[i]),
      .next_index (next_index[i]),
      .le         (le[i]),
      .lt         (lt[i]),
      .dist_r     (cell_dist[i]),
      .index_r    (cell_index[i])
    );
  end

  // Sequence: take requests, then drain the list at row end
  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    rank_nxt  = rank_r;
    last_nxt  = last_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fill_nxt = ins_fill;
          if (in_row_end) begin
            state_nxt = ST_EMIT;
            rank_nxt  = '0;
            last_nxt  = RK_W'(ins_fill - CNT_W'(1));
          end
        end
      end
      ST_EMIT: begin
        rank_nxt = rank_r + RK_W'(1);
        if (rank_r == last_r) begin
          state_nxt = ST_IDLE;
          fill_nxt  = '0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        fill_nxt  = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      rank_r  <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rank_r  <= rank_nxt;
      last_r  <= last_nxt;
    end
  end

  // Results come from the head cell
  assign out_valid            = (state_r == ST_EMIT);
  assign out_rank             = RANK_W'(rank_r);
  assign out_nearest_index    = cell_index[0];
  assign out_nearest_distance = cell_dist[0];
  assign out_last_of_row      = (state_r == ST_EMIT) && (rank_r == last_r);

  // Row end starts a burst at rank 0
  a_row_end_starts: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && in_row_end |=> out_valid && (out_rank == '0))
    else $error("row end did not start a result burst at rank 0");

  // Ranks step by one within a burst
  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_row |=>
      out_valid && (out_rank == RANK_W'($past(out_rank) + RANK_W'(1))))
    else $error("result burst broke off or skipped a rank");

  // Results leave in ascending distance order
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_row |=>
      (out_nearest_distance >= $past(out_nearest_distance)))
    else $error("results not in ascending distance order");

  // The last result frees the block
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_row |=> !busy && !out_valid)
    else $error("block still busy after the last result of a row");

endmodule

// ----- dv/tb_k_smallest_distance_selector.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the k smallest distance selector: drives distance rows,
// predicts the ranked nearest list per row and checks every result. Depends on ksds_pkg.
module tb_k_smallest_distance_selector import ksds_pkg::*;;

  localparam int unsigned K_MAX      = 16;
  localparam int unsigned INDEX_BITS = 16;
  localparam int unsigned DIST_BITS  = 32;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned MAX_GAP     = 20;
  localparam logic [ADDR_W-1:0] COUNT_ADDR = ADDR_W'(4 * REG_NEIGHBOUR_COUNT);

  typedef struct {
    logic [RANK_W-1:0]     rank;
    logic [INDEX_BITS-1:0] index;
    logic [DIST_BITS-1:0]  distance;
    logic                  last;
  } neighbour_t;

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [DIST_BITS-1:0]  in_distance;
  logic [INDEX_BITS-1:0] in_ref_index;
  logic                  in_row_end;
  logic                  out_valid;
  logic [RANK_W-1:0]     out_rank;
  logic [INDEX_BITS-1:0] out_nearest_index;
  logic [DIST_BITS-1:0]  out_nearest_distance;
  logic                  out_last_of_row;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_W-1:0]     paddr;
  logic [DATA_W-1:0]     pwdata;
  logic [DATA_W-1:0]     prdata;
  logic                  pready;

  // Predicted state of the block
  logic [DIST_BITS-1:0]  kept_dist [K_MAX];
  logic [INDEX_BITS-1:0] kept_idx [K_MAX];
  int unsigned           fill_level;
  logic [NC_W-1:0]       count_reg;
  neighbour_t            expected_neighbours [$];

  int unsigned error_count;
  int unsigned idle_pct;
  int unsigned quiet_cycles;

  k_smallest_distance_selector #(
    .K_MAX      (K_MAX),
    .INDEX_BITS (INDEX_BITS),
    .DIST_BITS  (DIST_BITS)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_distance          (in_distance),
    .in_ref_index         (in_ref_index),
    .in_row_end           (in_row_end),
    .out_valid            (out_valid),
    .out_rank             (out_rank),
    .out_nearest_index    (out_nearest_index),
    .out_nearest_distance (out_nearest_distance),
    .out_last_of_row      (out_last_of_row),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Insert one request into the predicted sorted list; on row end queue the ranked list
  function automatic void update_nearest_list(input logic [DIST_BITS-1:0] d,
                                              input logic [INDEX_BITS-1:0] idx,
                                              input logic row_end);
    int unsigned k;
    int unsigned pos;
    int unsigned top;
    int unsigned i;
    bit          do_insert;
    neighbour_t  n;
    k = count_reg;
    if (k == 0) k = 1;
    if (k > K_MAX) k = K_MAX;
    // cut the list when the count shrank mid-row
    if (fill_level > k) fill_level = k;
    pos = 0;
    while (pos < fill_level && kept_dist[pos] < d) pos++;
    do_insert = 1'b0;
    top = 0;
    if (fill_level < k) begin
      top = fill_level;
      fill_level++;
      do_insert = 1'b1;
    end else if (d < kept_dist[k-1]) begin
      top = k - 1;
      do_insert = 1'b1;
    end
    if (do_insert) begin
      for (i = top; i > pos; i--) begin
        kept_dist[i] = kept_dist[i-1];
        kept_idx[i]  = kept_idx[i-1];
      end
      kept_dist[pos] = d;
      kept_idx[pos]  = idx;
    end
    if (row_end) begin
      for (i = 0; i < fill_level; i++) begin
        n.rank     = RANK_W'(i);
        n.index    = kept_idx[i];
        n.distance = kept_dist[i];
        n.last     = (i + 1 == fill_level);
        expected_neighbours.push_back(n);
      end
      fill_level = 0;
    end
  endfunction

  // Send one distance request, with a random idle gap ahead of it
  task automatic send_request(input logic [DIST_BITS-1:0] d, input logic [INDEX_BITS-1:0] idx,
                              input logic row_end);
    int unsigned gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start        <= 1'b1;
    in_distance  <= d;
    in_ref_index <= idx;
    in_row_end   <= row_end;
    // hold until the block takes the request
    do @(posedge clk); while (busy);
    update_nearest_list(d, idx, row_end);
  endtask

  // Drop start, then wait until every expected result has come
  task automatic wait_drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_neighbours.size() != 0) @(posedge clk);
  endtask

  // Write the neighbour count while idle, then read it back
  task automatic write_count(input logic [DATA_W-1:0] value);
    wait_drain();
    @(negedge clk);
    start <= 1'b0;
    repeat (K_MAX + 2) @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= COUNT_ADDR;
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    count_reg = value[NC_W-1:0];
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== DATA_W'(count_reg)) report_mismatch("count readback", prdata, count_reg);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] pick_count();
    logic [DATA_W-1:0] value;
    value = $urandom;
    case ($urandom_range(5))
      0:       value[NC_W-1:0] = NC_W'(1);
      1:       value[NC_W-1:0] = NC_W'(K_MAX);
      2:       value[NC_W-1:0] = '0;
      3:       value[NC_W-1:0] = NC_W'(K_MAX + 1 + $urandom_range(31 - K_MAX - 1));
      default: value[NC_W-1:0] = NC_W'($urandom_range(31));
    endcase
    if ($urandom_range(1)) value[DATA_W-1:NC_W] = '0;
    return value;
  endfunction

  // Mix narrow ranges (ties), the top end and full-range values
  function automatic logic [DIST_BITS-1:0] pick_distance();
    case ($urandom_range(4))
      0:       return DIST_BITS'($urandom_range(7));
      1:       return {DIST_BITS{1'b1}} - DIST_BITS'($urandom_range(3));
      2:       return {16'($urandom_range(3)), 16'($urandom)};
      default: return DIST_BITS'($urandom);
    endcase
  endfunction

  // Extremes, ties, short rows, count limits and a mid-row count change
  task automatic test_directed_cases();
    idle_pct = 0;
    send_request(32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_request(32'h0000_0000, 16'h0000, 1'b1);
    // equal to the kept one with a full list: drop it
    send_request(32'd5, 16'd1, 1'b0);
    send_request(32'd5, 16'd2, 1'b1);
    write_count(32'd4);
    send_request(32'd7, 16'd1, 1'b0);
    send_request(32'd3, 16'd2, 1'b0);
    send_request(32'd7, 16'd3, 1'b0);
    send_request(32'd3, 16'd4, 1'b0);
    send_request(32'd9, 16'd5, 1'b1);
    // short row
    send_request(32'd100, 16'hAAAA, 1'b0);
    send_request(32'd50, 16'h5555, 1'b1);
    // hold off until every result has come, then a single-request row
    wait_drain();
    send_request(32'h8000_0000, 16'h8000, 1'b1);
    write_count(32'd0);
    send_request(32'd10, 16'd1, 1'b0);
    send_request(32'd2, 16'd2, 1'b1);
    write_count(32'hFFFF_FFFF);
    send_request(32'h7FFF_FFFF, 16'h7FFF, 1'b0);
    send_request(32'h0001_0000, 16'h0100, 1'b0);
    send_request(32'h0000_0001, 16'h0001, 1'b1);
    write_count(K_MAX);
    send_request(32'd40, 16'd1, 1'b0);
    send_request(32'd30, 16'd2, 1'b0);
    send_request(32'd20, 16'd3, 1'b0);
    send_request(32'd10, 16'd4, 1'b0);
    write_count(32'd2);
    send_request(32'd25, 16'd5, 1'b1);
  endtask

  // Random rows with random counts, now and then a count change inside a row
  task automatic test_random_rows(input int unsigned item_total, input int unsigned sender_idle);
    int unsigned sent;
    int unsigned len;
    int unsigned i;
    idle_pct = sender_idle;
    sent = 0;
    while (sent < item_total) begin
      if ($urandom_range(4) == 0) write_count(pick_count());
      len = $urandom_range(1, 24);
      for (i = 0; i < len; i++) begin
        if (i > 0 && $urandom_range(39) == 0) write_count(pick_count());
        send_request(pick_distance(), INDEX_BITS'($urandom), i + 1 == len);
      end
      sent += len;
    end
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    neighbour_t want;
    if (rst_n && out_valid) begin
      if (expected_neighbours.size() == 0) begin
        report_mismatch("unexpected result, index", out_nearest_index, 0);
      end else begin
        want = expected_neighbours.pop_front();
        if (out_rank !== want.rank) report_mismatch("rank", out_rank, want.rank);
        if (out_nearest_index !== want.index)
          report_mismatch("nearest_index", out_nearest_index, want.index);
        if (out_nearest_distance !== want.distance)
          report_mismatch("nearest_distance", out_nearest_distance, want.distance);
        if (out_last_of_row !== want.last)
          report_mismatch("last_of_row", out_last_of_row, want.last);
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n        = 1'b0;
    start        = 1'b0;
    in_distance  = '0;
    in_ref_index = '0;
    in_row_end   = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    error_count  = 0;
    idle_pct     = 0;
    quiet_cycles = 0;
    fill_level   = 0;
    count_reg    = NC_W'(1);
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_directed_cases();
    test_random_rows(170, 0);
    test_random_rows(170, 62);
    test_random_rows(170, 13);

    @(negedge clk);
    start <= 1'b0;
    wait_drain();
    repeat (K_MAX + 4) @(posedge clk);
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ksds_pkg.sv
hdl/ksds_cell.sv
hdl/k_smallest_distance_selector.sv
dv/tb_k_smallest_distance_selector.sv
